// ===== hw/rtl/rcfd_pkg.sv =====
package rcfd_pkg;

  localparam int unsigned CH_W       = 11;
  localparam int unsigned TIMER_W    = 8;
  localparam int unsigned KEY_W      = 16;
  localparam int unsigned NUM_MOUSE_BTN = 2;
  localparam int unsigned NUM_KEYS_DEFAULT = 16;
  localparam int unsigned REPORT_BTN = 18;
  localparam int unsigned NUM_CH     = 5;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [CH_W-1:0]    CH_MIN_RST      = 11'd364;
  localparam logic [CH_W-1:0]    CH_MAX_RST      = 11'd1684;
  localparam logic [CH_W-1:0]    CH_CENTER_RST   = 11'd1024;
  localparam logic [TIMER_W-1:0] FRAME_PERIOD_RST = 8'd14;
  localparam logic [TIMER_W-1:0] PRESS_TH_RST    = 8'd40;
  localparam logic [TIMER_W-1:0] HOLD_TH_RST     = 8'd160;

  // x * 16384 / 660 == (x * SCALE_MULT) >> SCALE_SHIFT, exact for x < 2048
  localparam logic [23:0] SCALE_MULT  = 24'd13015053;
  localparam int unsigned SCALE_SHIFT = 19;

  localparam logic [1:0] SW_UP   = 2'd1;
  localparam logic [1:0] SW_DOWN = 2'd2;
  localparam logic [1:0] SW_MID  = 2'd3;

  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_UP_MID   = 3'd1;
  localparam logic [2:0] EV_MID_DOWN = 3'd2;
  localparam logic [2:0] EV_DOWN_MID = 3'd3;
  localparam logic [2:0] EV_MID_UP   = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CH_MIN       = 3'd0,
    CFG_CH_MAX       = 3'd1,
    CFG_CH_CENTER    = 3'd2,
    CFG_FRAME_PERIOD = 3'd3,
    CFG_PRESS_TH     = 3'd4,
    CFG_HOLD_TH      = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BTN_RELEASED = 2'd0,
    BTN_PRESSED  = 2'd1,
    BTN_HOLD     = 2'd2
  } btn_state_e;

  typedef struct packed {
    logic [CH_W-1:0]    channel_min;
    logic [CH_W-1:0]    channel_max;
    logic [CH_W-1:0]    channel_center;
    logic [TIMER_W-1:0] frame_period;
    logic [TIMER_W-1:0] press_threshold;
    logic [TIMER_W-1:0] hold_threshold;
  } cfg_t;

  typedef struct packed {
    logic [TIMER_W-1:0] frame_period;
    logic [TIMER_W-1:0] press_threshold;
    logic [TIMER_W-1:0] hold_threshold;
  } btn_cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]   stick_ch0;
    logic [CH_W-1:0]   stick_ch1;
    logic [CH_W-1:0]   stick_ch2;
    logic [CH_W-1:0]   stick_ch3;
    logic [CH_W-1:0]   wheel_raw;
    logic [1:0]        switch_right_raw;
    logic [1:0]        switch_left_raw;
    logic signed [15:0] mouse_x;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_z;
    logic [1:0]        mouse_buttons;
    logic [KEY_W-1:0]  key_bits;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        stick_values;
    logic signed [15:0] wheel_value;
    logic [1:0]         switch_right_state;
    logic [2:0]         switch_right_event;
    logic [1:0]         switch_left_state;
    logic [2:0]         switch_left_event;
    logic [47:0]        mouse_motion;
    logic [2*REPORT_BTN-1:0] button_states;
  } out_item_t;

  function automatic logic [2:0] switch_event(logic [1:0] prev, logic [1:0] now);
    logic [2:0] ev;
    ev = EV_NONE;
    if (prev == SW_UP && now == SW_MID) ev = EV_UP_MID;
    if (prev == SW_MID && now == SW_DOWN) ev = EV_MID_DOWN;
    if (prev == SW_DOWN && now == SW_MID) ev = EV_DOWN_MID;
    if (prev == SW_MID && now == SW_UP) ev = EV_MID_UP;
    return ev;
  endfunction

endpackage

// ===== hw/rtl/rcfd_scale_lane.sv =====
module rcfd_scale_lane
  import rcfd_pkg::*;
(
  input  logic               neg_i,
  input  logic [CH_W-1:0]    mag_i,
  output logic signed [15:0] value_o
);

  localparam int unsigned PROD_W = CH_W + $bits(SCALE_MULT);

  logic [PROD_W-1:0] prod;
  logic [15:0]       quot;

  assign prod = PROD_W'(mag_i) * PROD_W'(SCALE_MULT);
  assign quot = prod[SCALE_SHIFT +: 16];

  // truncation toward zero: scale the magnitude, then restore the sign
  always_comb begin
    if (neg_i) begin
      if (quot > 16'd32768) value_o = 16'sh8000;
      else value_o = signed'(16'(~quot + 16'd1));
    end else begin
      if (quot > 16'd32767) value_o = 16'sh7fff;
      else value_o = signed'(quot);
    end
  end

endmodule

// ===== hw/rtl/rcfd_button_lane.sv =====
module rcfd_button_lane
  import rcfd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       press_i,
  input  btn_cfg_t   cfg_i,
  output btn_state_e status_o
);

  btn_state_e         status_q, status_d;
  logic [TIMER_W-1:0] timer_q, timer_d;
  logic [TIMER_W:0]   sum;
  logic [TIMER_W-1:0] sum_sat;

  assign sum     = {1'b0, timer_q} + {1'b0, cfg_i.frame_period};
  assign sum_sat = sum[TIMER_W] ? {TIMER_W{1'b1}} : sum[TIMER_W-1:0];

  always_comb begin
    status_d = BTN_RELEASED;
    timer_d  = '0;
    if (press_i) begin
      case (status_q)
        BTN_RELEASED: begin
          timer_d = sum_sat;
          if (sum_sat > cfg_i.press_threshold) status_d = BTN_PRESSED;
        end
        BTN_PRESSED: begin
          timer_d = sum_sat;
          // hold lasts one frame, then the timer restarts
          if (sum_sat > cfg_i.hold_threshold) begin
            status_d = BTN_HOLD;
            timer_d  = '0;
          end
        end
        default: begin
          status_d = BTN_RELEASED;
          timer_d  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q <= BTN_RELEASED;
      timer_q  <= '0;
    end else if (en_i) begin
      status_q <= status_d;
      timer_q  <= timer_d;
    end
  end

  assign status_o = status_d;

endmodule

// ===== hw/rtl/rc_frame_decoder.sv =====
// an accepted item is registered in the first stage, then in the output register
// throughput: one item per cycle while the output is not stalled; the stick and wheel scaling runs in its own stage
// an item with a stick or wheel value outside the valid range gives no result
// reset: config registers take their default values, switch history clears to zero,
// every button lane is in the released state and every press timer is zero
module rc_frame_decoder
  import rcfd_pkg::*;
#(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  localparam int unsigned NUM_BTN = NUM_MOUSE_BTN + NUM_KEYS;
  localparam int unsigned NUM_REP = (NUM_BTN < REPORT_BTN) ? NUM_BTN : REPORT_BTN;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{CH_MIN_RST, CH_MAX_RST, CH_CENTER_RST,
                 FRAME_PERIOD_RST, PRESS_TH_RST, HOLD_TH_RST};
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CH_MIN:       cfg_q.channel_min     <= cfg_wdata_i[CH_W-1:0];
        CFG_CH_MAX:       cfg_q.channel_max     <= cfg_wdata_i[CH_W-1:0];
        CFG_CH_CENTER:    cfg_q.channel_center  <= cfg_wdata_i[CH_W-1:0];
        CFG_FRAME_PERIOD: cfg_q.frame_period    <= cfg_wdata_i[TIMER_W-1:0];
        CFG_PRESS_TH:     cfg_q.press_threshold <= cfg_wdata_i[TIMER_W-1:0];
        CFG_HOLD_TH:      cfg_q.hold_threshold  <= cfg_wdata_i[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic s1_v_q, s1_v_d;
  logic out_v_q, out_v_d;
  logic out_ready, s1_ready, accept, keep, upd;

  assign out_ready  = !out_v_q || !out_stall_i;
  assign s1_ready   = !s1_v_q || out_ready;
  assign accept     = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;
  assign upd        = accept && keep;

  // range check and centering, one lane per channel
  logic [CH_W-1:0] raw [NUM_CH];
  logic [NUM_CH-1:0] ok;
  logic [NUM_CH-1:0] neg_d;
  logic [CH_W-1:0]   mag_d [NUM_CH];

  assign raw[0] = in_data_i.stick_ch0;
  assign raw[1] = in_data_i.stick_ch1;
  assign raw[2] = in_data_i.stick_ch2;
  assign raw[3] = in_data_i.stick_ch3;
  assign raw[4] = in_data_i.wheel_raw;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_center
    logic [CH_W:0] diff;
    assign ok[c]    = (raw[c] >= cfg_q.channel_min) && (raw[c] <= cfg_q.channel_max);
    assign diff     = {1'b0, raw[c]} - {1'b0, cfg_q.channel_center};
    assign neg_d[c] = diff[CH_W];
    assign mag_d[c] = diff[CH_W] ? CH_W'(~diff + 1'b1) : diff[CH_W-1:0];
  end

  assign keep = &ok;

  // switches
  logic [1:0] sw_r_prev_q, sw_l_prev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_r_prev_q <= '0;
      sw_l_prev_q <= '0;
    end else if (upd) begin
      sw_r_prev_q <= in_data_i.switch_right_raw;
      sw_l_prev_q <= in_data_i.switch_left_raw;
    end
  end

  // button lanes
  btn_cfg_t   btn_cfg;
  btn_state_e btn_st [NUM_BTN];
  logic [2*REPORT_BTN-1:0] btn_pack;

  assign btn_cfg = '{cfg_q.frame_period, cfg_q.press_threshold, cfg_q.hold_threshold};

  for (genvar b = 0; b < NUM_BTN; b++) begin : g_btn
    logic press;
    if (b < NUM_MOUSE_BTN) begin : g_mouse
      assign press = in_data_i.mouse_buttons[b];
    end else if (b - NUM_MOUSE_BTN < KEY_W) begin : g_key
      assign press = in_data_i.key_bits[b - NUM_MOUSE_BTN];
    end else begin : g_none
      assign press = 1'b0;
    end
    rcfd_button_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (upd),
      .press_i  (press),
      .cfg_i    (btn_cfg),
      .status_o (btn_st[b])
    );
  end

  always_comb begin
    btn_pack = '0;
    for (int i = 0; i < NUM_REP; i++) begin
      btn_pack[2*i +: 2] = btn_st[i];
    end
  end

  // first stage registers
  logic [NUM_CH-1:0] s1_neg_q;
  logic [CH_W-1:0]   s1_mag_q [NUM_CH];
  logic [1:0]        s1_sr_q, s1_sl_q;
  logic [2:0]        s1_evr_q, s1_evl_q;
  logic [47:0]       s1_mouse_q;
  logic [2*REPORT_BTN-1:0] s1_btn_q;

  always_comb begin
    s1_v_d = s1_v_q;
    if (s1_ready) s1_v_d = upd;
    out_v_d = out_v_q;
    if (out_ready) out_v_d = s1_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_neg_q   <= neg_d;
      s1_mag_q   <= mag_d;
      s1_sr_q    <= in_data_i.switch_right_raw;
      s1_sl_q    <= in_data_i.switch_left_raw;
      s1_evr_q   <= switch_event(sw_r_prev_q, in_data_i.switch_right_raw);
      s1_evl_q   <= switch_event(sw_l_prev_q, in_data_i.switch_left_raw);
      s1_mouse_q <= {in_data_i.mouse_z, in_data_i.mouse_y, in_data_i.mouse_x};
      s1_btn_q   <= btn_pack;
    end
  end

  // scaling lanes
  logic signed [15:0] scaled [NUM_CH];

  for (genvar c = 0; c < NUM_CH; c++) begin : g_scale
    rcfd_scale_lane u_scale (
      .neg_i   (s1_neg_q[c]),
      .mag_i   (s1_mag_q[c]),
      .value_o (scaled[c])
    );
  end

  // merge into the output register
  out_item_t out_q, out_d;

  always_comb begin
    out_d.stick_values       = {scaled[3], scaled[2], scaled[1], scaled[0]};
    out_d.wheel_value        = scaled[4];
    out_d.switch_right_state = s1_sr_q;
    out_d.switch_right_event = s1_evr_q;
    out_d.switch_left_state  = s1_sl_q;
    out_d.switch_left_event  = s1_evl_q;
    out_d.mouse_motion       = s1_mouse_q;
    out_d.button_states      = s1_btn_q;
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s1_v_q) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== sim/rcfd_checker.sv =====
module rcfd_checker
  import rcfd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    frames_kept_o,
  output int                    frames_dropped_o,
  output int                    results_seen_o,
  output int                    holds_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BTN = NUM_MOUSE_BTN + KEY_W;

  cfg_t        regs;
  logic [1:0]  right_was;
  logic [1:0]  left_was;
  btn_state_e  btn_st [NUM_BTN];
  logic [7:0]  btn_tmr [NUM_BTN];
  out_item_t   expected_reports [$];
  bit          keep;
  out_item_t   rep;
  out_item_t   want;

  // center and scale to q2.14, truncating toward zero, then saturate
  function automatic logic [15:0] to_q14(logic [CH_W-1:0] raw);
    int d;
    int q;
    d = int'(raw) - int'(regs.channel_center);
    q = (d * 16384) / 660;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic logic [2:0] transition(logic [1:0] was, logic [1:0] now);
    case ({was, now})
      {SW_UP, SW_MID}:   return EV_UP_MID;
      {SW_MID, SW_DOWN}: return EV_MID_DOWN;
      {SW_DOWN, SW_MID}: return EV_DOWN_MID;
      {SW_MID, SW_UP}:   return EV_MID_UP;
      default:           return EV_NONE;
    endcase
  endfunction

  task automatic decode_frame(input in_item_t f, output bit ok, output out_item_t r);
    logic [CH_W-1:0]    ch [NUM_CH];
    logic [NUM_BTN-1:0] down;
    int                 t;
    ch = '{f.stick_ch0, f.stick_ch1, f.stick_ch2, f.stick_ch3, f.wheel_raw};
    ok = 1'b1;
    r = '0;
    for (int i = 0; i < NUM_CH; i++) begin
      if (ch[i] < regs.channel_min || ch[i] > regs.channel_max) ok = 1'b0;
    end
    if (!ok) return;
    r.stick_values = {to_q14(ch[3]), to_q14(ch[2]), to_q14(ch[1]), to_q14(ch[0])};
    r.wheel_value = to_q14(ch[4]);
    r.switch_right_state = f.switch_right_raw;
    r.switch_left_state = f.switch_left_raw;
    r.switch_right_event = transition(right_was, f.switch_right_raw);
    r.switch_left_event = transition(left_was, f.switch_left_raw);
    right_was = f.switch_right_raw;
    left_was = f.switch_left_raw;
    r.mouse_motion = {f.mouse_z, f.mouse_y, f.mouse_x};
    down = {f.key_bits, f.mouse_buttons};
    for (int i = 0; i < NUM_BTN; i++) begin
      t = int'(btn_tmr[i]) + int'(regs.frame_period);
      if (t > 255) t = 255;
      if (!down[i]) begin
        btn_st[i] = BTN_RELEASED;
        btn_tmr[i] = '0;
      end else begin
        case (btn_st[i])
          BTN_RELEASED: begin
            btn_tmr[i] = t[7:0];
            btn_st[i] = (t > int'(regs.press_threshold)) ? BTN_PRESSED : BTN_RELEASED;
          end
          BTN_PRESSED: begin
            // pressed long enough goes to hold, otherwise drops back but keeps its time
            if (t > int'(regs.hold_threshold)) begin
              btn_st[i] = BTN_HOLD;
              btn_tmr[i] = '0;
              holds_seen_o++;
            end else begin
              btn_st[i] = BTN_RELEASED;
              btn_tmr[i] = t[7:0];
            end
          end
          default: begin
            btn_st[i] = BTN_RELEASED;
            btn_tmr[i] = '0;
          end
        endcase
      end
      r.button_states[2*i +: 2] = btn_st[i];
    end
  endtask

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs = '{CH_MIN_RST, CH_MAX_RST, CH_CENTER_RST, FRAME_PERIOD_RST, PRESS_TH_RST,
               HOLD_TH_RST};
      right_was = '0;
      left_was = '0;
      for (int i = 0; i < NUM_BTN; i++) begin
        btn_st[i] = BTN_RELEASED;
        btn_tmr[i] = '0;
      end
      expected_reports.delete();
      fail_count_o = 0;
      pending_o = 0;
      frames_kept_o = 0;
      frames_dropped_o = 0;
      results_seen_o = 0;
      holds_seen_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CH_MIN:       regs.channel_min = cfg_wdata_i;
          CFG_CH_MAX:       regs.channel_max = cfg_wdata_i;
          CFG_CH_CENTER:    regs.channel_center = cfg_wdata_i;
          CFG_FRAME_PERIOD: regs.frame_period = cfg_wdata_i[TIMER_W-1:0];
          CFG_PRESS_TH:     regs.press_threshold = cfg_wdata_i[TIMER_W-1:0];
          CFG_HOLD_TH:      regs.hold_threshold = cfg_wdata_i[TIMER_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        decode_frame(in_data_i, keep, rep);
        if (keep) begin
          expected_reports.insert(expected_reports.size(), rep);
          frames_kept_o++;
        end else begin
          frames_dropped_o++;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        results_seen_o++;
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result, expected nothing, actual %0h", $time, out_data_i);
          fail_count_o++;
        end else begin
          want = expected_reports.pop_front();
          check_field("stick_values", want.stick_values, out_data_i.stick_values);
          check_field("wheel_value", want.wheel_value, out_data_i.wheel_value);
          check_field("switch_right_state", want.switch_right_state,
                      out_data_i.switch_right_state);
          check_field("switch_right_event", want.switch_right_event,
                      out_data_i.switch_right_event);
          check_field("switch_left_state", want.switch_left_state,
                      out_data_i.switch_left_state);
          check_field("switch_left_event", want.switch_left_event,
                      out_data_i.switch_left_event);
          check_field("mouse_motion", want.mouse_motion, out_data_i.mouse_motion);
          check_field("button_states", want.button_states, out_data_i.button_states);
        end
      end
      pending_o = expected_reports.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
module tb;
  import rcfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int NUM_BTN = NUM_MOUSE_BTN + KEY_W;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;

  int fails, pending, kept, dropped, results, holds;

  bit                 in_taken = 1'b0;
  bit                 out_taken = 1'b0;
  bit                 quiet = 1'b0;
  int                 stall_left = 0;
  int                 idle_cycles = 0;
  int                 n_settings = 0;
  cfg_t               cur;
  logic [1:0]         sw_r = SW_MID;
  logic [1:0]         sw_l = SW_MID;
  logic [NUM_BTN-1:0] held = '0;

  rc_frame_decoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  rcfd_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .fail_count_o    (fails),
    .pending_o       (pending),
    .frames_kept_o   (kept),
    .frames_dropped_o(dropped),
    .results_seen_o  (results),
    .holds_seen_o    (holds)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    in_taken <= in_valid && !in_stall;
    out_taken <= out_valid && !out_stall;
  end

  // receiver: a fresh stall length after every accepted result
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) stall_left = quiet ? 0 : $urandom_range(0, 19);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding", $time,
                 IDLE_LIMIT, pending);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_frame(input in_item_t f);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= f;
    do @(negedge clk); while (!in_taken);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // dropped frames leave nothing to wait on, so let the pipeline settle before going on
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(CFG_CH_MIN, c.channel_min);
    write_reg(CFG_CH_MAX, c.channel_max);
    write_reg(CFG_CH_CENTER, c.channel_center);
    write_reg(CFG_FRAME_PERIOD, CFG_DATA_W'(c.frame_period));
    write_reg(CFG_PRESS_TH, CFG_DATA_W'(c.press_threshold));
    write_reg(CFG_HOLD_TH, CFG_DATA_W'(c.hold_threshold));
    cfg_we <= 1'b0;
    cur = c;
    n_settings++;
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    c.channel_min = CH_W'($urandom_range(0, 1000));
    c.channel_max = CH_W'($urandom_range(c.channel_min, 2047));
    c.channel_center = CH_W'($urandom_range(0, 2047));
    c.frame_period = TIMER_W'($urandom_range(1, 255));
    c.press_threshold = TIMER_W'($urandom_range(0, 255));
    c.hold_threshold = TIMER_W'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [CH_W-1:0] pick_raw(bit bad);
    if (bad) begin
      if (cur.channel_min > 0 && ($urandom_range(0, 1) || cur.channel_max == 2047))
        return CH_W'($urandom_range(0, cur.channel_min - 1));
      if (cur.channel_max < 2047)
        return CH_W'($urandom_range(cur.channel_max + 1, 2047));
    end
    case ($urandom_range(0, 9))
      0:       return cur.channel_min;
      1:       return cur.channel_max;
      default: return CH_W'($urandom_range(cur.channel_min, cur.channel_max));
    endcase
  endfunction

  // mostly legal switch moves, now and then a random code
  function automatic logic [1:0] step_switch(logic [1:0] s);
    case ($urandom_range(0, 7))
      0: return 2'($urandom_range(0, 3));
      1: return s;
      default: begin
        case (s)
          SW_UP:   return SW_MID;
          SW_MID:  return $urandom_range(0, 1) ? SW_UP : SW_DOWN;
          default: return SW_MID;
        endcase
      end
    endcase
  endfunction

  function automatic logic [15:0] pick_motion();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      default: return 16'($urandom_range(0, 16'hffff));
    endcase
  endfunction

  function automatic in_item_t next_frame();
    in_item_t        f;
    logic [CH_W-1:0] ch [NUM_CH];
    int              bad_ch;
    logic [NUM_BTN-1:0] btn;
    bad_ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NUM_CH - 1) : NUM_CH;
    for (int i = 0; i < NUM_CH; i++) ch[i] = pick_raw(i == bad_ch);
    sw_r = step_switch(sw_r);
    sw_l = step_switch(sw_l);
    // buttons stay down for long runs so the timers can reach hold
    for (int i = 0; i < NUM_BTN; i++) begin
      if ($urandom_range(0, 19) == 0) held[i] = ~held[i];
    end
    btn = ($urandom_range(0, 24) == 0) ? NUM_BTN'($urandom()) : held;
    f.stick_ch0 = ch[0];
    f.stick_ch1 = ch[1];
    f.stick_ch2 = ch[2];
    f.stick_ch3 = ch[3];
    f.wheel_raw = ch[4];
    f.switch_right_raw = sw_r;
    f.switch_left_raw = sw_l;
    f.mouse_x = pick_motion();
    f.mouse_y = pick_motion();
    f.mouse_z = pick_motion();
    f.mouse_buttons = btn[1:0];
    f.key_bits = btn[NUM_BTN-1:2];
    return f;
  endfunction

  // runs until the given number of in-range frames has gone in
  task automatic send_random(input int want);
    int target;
    target = kept + want;
    while (kept < target) send_frame(next_frame());
  endtask

  initial begin
    in_item_t f;
    in_item_t g;
    rst_n = 1'b0;
    cur = '{CH_MIN_RST, CH_MAX_RST, CH_CENTER_RST, FRAME_PERIOD_RST, PRESS_TH_RST,
            HOLD_TH_RST};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // directed frames at reset settings
    f = '0;
    f.stick_ch0 = 11'd1024;
    f.stick_ch1 = 11'd1024;
    f.stick_ch2 = 11'd1024;
    f.stick_ch3 = 11'd1024;
    f.wheel_raw = 11'd1024;
    f.switch_right_raw = SW_UP;
    f.switch_left_raw = SW_UP;
    send_frame(f);
    f.stick_ch0 = 11'd364;
    f.stick_ch1 = 11'd1684;
    f.stick_ch2 = 11'd365;
    f.stick_ch3 = 11'd1683;
    f.wheel_raw = 11'd364;
    f.switch_right_raw = SW_MID;
    f.switch_left_raw = SW_MID;
    f.mouse_x = 16'h8000;
    f.mouse_y = 16'h7fff;
    f.mouse_z = 16'hffff;
    send_frame(f);
    // out of range frames must leave the switch history alone
    g = f;
    g.stick_ch0 = 11'd363;
    g.switch_right_raw = SW_DOWN;
    send_frame(g);
    g = f;
    g.wheel_raw = 11'd1685;
    send_frame(g);
    g = f;
    g.stick_ch3 = 11'd0;
    send_frame(g);
    g = f;
    g.stick_ch1 = 11'd2047;
    send_frame(g);
    f.wheel_raw = 11'd1684;
    f.switch_right_raw = SW_DOWN;
    f.switch_left_raw = SW_DOWN;
    f.mouse_x = 16'h7fff;
    f.mouse_y = 16'h8000;
    f.mouse_z = 16'h0000;
    send_frame(f);
    f.switch_right_raw = SW_MID;
    f.switch_left_raw = SW_MID;
    send_frame(f);
    f.switch_right_raw = SW_UP;
    f.switch_left_raw = SW_UP;
    send_frame(f);
    f.switch_right_raw = SW_DOWN;
    f.switch_left_raw = 2'b00;
    send_frame(f);
    f.switch_right_raw = 2'b00;
    f.switch_left_raw = SW_MID;
    send_frame(f);
    // everything held down: walks through pressed into hold and back to released
    f.mouse_buttons = 2'b11;
    f.key_bits = 16'hffff;
    for (int i = 0; i < 13; i++) begin
      f.mouse_x = 16'(i * 4099);
      send_frame(f);
    end
    f.mouse_buttons = 2'b01;
    f.key_bits = 16'h5a5a;
    send_frame(f);

    send_random(50);
    drain();
    apply_config('{11'd0, 11'd2047, 11'd0, 8'd255, 8'd0, 8'd0});
    send_random(60);
    drain();
    apply_config('{11'd0, 11'd2047, 11'd2047, 8'd1, 8'd255, 8'd255});
    send_random(60);
    drain();
    apply_config(random_config());
    send_random(60);
    drain();
    // empty valid range: every frame is dropped
    apply_config('{11'd1500, 11'd400, 11'd900, 8'd20, 8'd30, 8'd90});
    repeat (15) send_frame(next_frame());
    drain();
    apply_config('{11'd700, 11'd700, 11'd700, 8'd8, 8'd20, 8'd50});
    send_random(40);
    drain();
    apply_config(random_config());
    send_random(55);
    drain();
    apply_config('{CH_MIN_RST, CH_MAX_RST, CH_CENTER_RST, FRAME_PERIOD_RST, PRESS_TH_RST,
                   HOLD_TH_RST});
    send_random(55);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    $display("frames decoded: %0d, dropped as out of range: %0d, results checked: %0d",
             kept, dropped, results);
    $display("register settings applied: %0d, hold grades reached: %0d, mismatches: %0d",
             n_settings, holds, fails);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/rcfd_pkg.sv
hw/rtl/rcfd_scale_lane.sv
hw/rtl/rcfd_button_lane.sv
hw/rtl/rc_frame_decoder.sv
sim/rcfd_checker.sv
sim/tb.sv
